>>> hdl/cvf_pkg.sv
// ----------------------------------------------------------------------------
// cvf_pkg: shared constants and types for the 3x3 RGBA convolution core
// Geometry limits, arithmetic widths, register indexes and the structs that
// carry control between the core's modules.
// ----------------------------------------------------------------------------
package cvf_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COEF_BITS = 8;

   localparam int CH_BITS   = 8;
   localparam int LANES     = 4;
   localparam int PIX_BITS  = CH_BITS * LANES;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WEFF_BITS = COL_BITS + 1;
   localparam int WREG_BITS = 12;
   localparam int HREG_BITS = 12;
   localparam int ROW_BITS  = HREG_BITS + 1;
   localparam int KREG_BITS = 24;
   localparam int KPACK_BITS = 3 * COEF_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [CSR_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_KERNEL_TOP   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_KERNEL_MID   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_KERNEL_BOT   = 3'd4;

   localparam logic [WREG_BITS-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [HREG_BITS-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [KREG_BITS-1:0] KERNEL_RESET = 24'h010101;

   // lane arithmetic: pixel (as signed) times coefficient, sum of nine taps
   localparam int PROD_BITS = COEF_BITS + CH_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 4;
   localparam int ABS_BITS  = SUM_BITS - 1;
   // divide by nine as multiply by rounded-up reciprocal, exact below 2^ABS_BITS
   localparam int DIV_SHIFT = ABS_BITS + 4;
   localparam int MULT_BITS = DIV_SHIFT - 2;
   localparam logic [63:0] DIV_MULT = ((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9;

   typedef logic [PIX_BITS-1:0] pix_type;
   typedef logic [2:0][2:0][PIX_BITS-1:0] win_type;
   typedef logic [2:0][2:0][CH_BITS-1:0] chan_win_type;
   typedef logic [2:0][2:0][COEF_BITS-1:0] kern_type;

   typedef struct packed {
      logic top;
      logic bot;
      logic left;
      logic right;
   } cvf_mask_type;

   typedef struct packed {
      logic accept;
      logic s1_fire;
      logic geo_clear;
   } cvf_cmd_type;

   typedef struct packed {
      logic step;
      logic s1_emit;
   } cvf_stat_type;

   typedef struct packed {
      logic                rd_en;
      logic [COL_BITS-1:0] rd_addr;
      pix_type             cur_wdata;
      logic                above_we;
      logic [COL_BITS-1:0] above_waddr;
      pix_type             above_wdata;
   } cvf_lb_req_type;

   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
   } cvf_lane_en_type;

endpackage

>>> hdl/cvf_linebuf.sv
// ----------------------------------------------------------------------------
// cvf_linebuf: two line buffers of packed pixels
// Current line is read and rewritten at the input column; the line above is
// written when the item leaves stage 1, with the old current value, with a
// bypass for a read of the same column at that edge.
// ----------------------------------------------------------------------------
module cvf_linebuf (
   input  logic                    clock,
   input  cvf_pkg::cvf_lb_req_type req,
   output cvf_pkg::pix_type        up1,
   output cvf_pkg::pix_type        up2
);
   import cvf_pkg::*;

   pix_type cur_mem   [MAX_WIDTH];
   pix_type above_mem [MAX_WIDTH];

   pix_type up1_ff;
   pix_type up2_ff;
   logic    byp_ff;
   pix_type byp_data_ff;

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         up1_ff               <= cur_mem[req.rd_addr];
         up2_ff               <= above_mem[req.rd_addr];
         cur_mem[req.rd_addr] <= req.cur_wdata;
         byp_ff               <= req.above_we && (req.above_waddr == req.rd_addr);
         byp_data_ff          <= req.above_wdata;
      end
      if (req.above_we) begin
         above_mem[req.above_waddr] <= req.above_wdata;
      end
   end

   assign up1 = up1_ff;
   assign up2 = byp_ff ? byp_data_ff : up2_ff;

endmodule

>>> hdl/cvf_ctrl.sv
// ----------------------------------------------------------------------------
// cvf_ctrl: frame position tracking and 3x3 window
// Input and output position counters, flush handling, edge masks, and the
// window shift fed from the line buffers.
// ----------------------------------------------------------------------------
module cvf_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  cvf_pkg::cvf_cmd_type           cmd,
   input  logic                           req_func,
   input  cvf_pkg::pix_type               req_pix,
   input  logic [cvf_pkg::WEFF_BITS-1:0]  w_eff,
   input  logic [cvf_pkg::HREG_BITS-1:0]  h_eff,
   output cvf_pkg::cvf_stat_type          stat,
   output cvf_pkg::cvf_lb_req_type        lb_req,
   input  cvf_pkg::pix_type               up1,
   input  cvf_pkg::pix_type               up2,
   output cvf_pkg::win_type               win,
   output cvf_pkg::cvf_mask_type          s2_mask,
   output logic                           s2_fe
);
   import cvf_pkg::*;

   logic [COL_BITS-1:0]  col_ff,  col_in;
   logic [ROW_BITS-1:0]  row_ff,  row_in;
   logic [COL_BITS-1:0]  ocol_ff, ocol_in;
   logic [HREG_BITS-1:0] orow_ff, orow_in;

   logic                 pixel_phase, step, warm, fe;
   logic                 col_wrap, ocol_wrap, orow_last;
   logic [WEFF_BITS-1:0] col_inc, ocol_inc;
   pix_type              pix;
   cvf_mask_type         mask;

   pix_type              s1_pix_ff;
   logic [COL_BITS-1:0]  s1_addr_ff;
   logic                 s1_emit_ff;
   cvf_mask_type         s1_mask_ff;
   logic                 s1_fe_ff;

   win_type              win_ff;
   cvf_mask_type         s2_mask_ff;
   logic                 s2_fe_ff;

   always_comb begin
      pixel_phase = row_ff < ROW_BITS'(h_eff);
      step        = cmd.accept && !(pixel_phase && req_func);
      pix         = pixel_phase ? req_pix : '0;
      warm        = (row_ff == '0) || ((row_ff == ROW_BITS'(1)) && (col_ff == '0));

      col_inc     = {1'b0, col_ff} + WEFF_BITS'(1);
      col_wrap    = col_inc == w_eff;
      ocol_inc    = {1'b0, ocol_ff} + WEFF_BITS'(1);
      ocol_wrap   = ocol_inc == w_eff;
      orow_last   = orow_ff == (h_eff - HREG_BITS'(1));
      fe          = ocol_wrap && orow_last;

      mask.top    = orow_ff != '0;
      mask.bot    = !orow_last;
      mask.left   = ocol_ff != '0;
      mask.right  = !ocol_wrap;

      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (step) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_inc[COL_BITS-1:0];
         end
         if (!warm) begin
            if (ocol_wrap) begin
               ocol_in = '0;
               orow_in = orow_ff + HREG_BITS'(1);
            end else begin
               ocol_in = ocol_inc[COL_BITS-1:0];
            end
            if (fe) begin
               col_in  = '0;
               row_in  = '0;
               ocol_in = '0;
               orow_in = '0;
            end
         end
      end
      if (cmd.geo_clear) begin
         col_in  = '0;
         row_in  = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_pix_ff  <= pix;
         s1_addr_ff <= col_ff;
         s1_emit_ff <= !warm;
         s1_mask_ff <= mask;
         s1_fe_ff   <= fe;
      end
      if (cmd.s1_fire) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up2;
         win_ff[1][2] <= up1;
         win_ff[2][2] <= s1_pix_ff;
         s2_mask_ff   <= s1_mask_ff;
         s2_fe_ff     <= s1_fe_ff;
      end
   end

   assign stat.step          = step;
   assign stat.s1_emit       = s1_emit_ff;

   assign lb_req.rd_en       = step;
   assign lb_req.rd_addr     = col_ff;
   assign lb_req.cur_wdata   = pix;
   assign lb_req.above_we    = cmd.s1_fire;
   assign lb_req.above_waddr = s1_addr_ff;
   assign lb_req.above_wdata = up1;

   assign win     = win_ff;
   assign s2_mask = s2_mask_ff;
   assign s2_fe   = s2_fe_ff;

endmodule

>>> hdl/cvf_lane.sv
// ----------------------------------------------------------------------------
// cvf_lane: one color channel of the convolution
// Masked tap products, nine-way sum with magnitude and sign, then divide by
// nine through a reciprocal multiply. Three register stages.
// ----------------------------------------------------------------------------
module cvf_lane (
   input  logic                         clock,
   input  cvf_pkg::cvf_lane_en_type     en,
   input  cvf_pkg::chan_win_type        win,
   input  cvf_pkg::kern_type            kern,
   input  cvf_pkg::cvf_mask_type        mask,
   output logic [cvf_pkg::CH_BITS-1:0]  mag,
   output logic                         neg
);
   import cvf_pkg::*;

   localparam int QP_BITS = ABS_BITS + MULT_BITS;

   logic signed [PROD_BITS-1:0] prod_in [3][3];
   logic signed [PROD_BITS-1:0] prod_ff [3][3];
   logic signed [SUM_BITS-1:0]  sum_in;
   logic [ABS_BITS-1:0]         abs_in, abs_ff;
   logic                        neg4_ff, neg5_ff;
   logic [QP_BITS-1:0]          quot_full;
   logic [CH_BITS-1:0]          quot_ff;

   always_comb begin
      logic                        tap_on;
      logic signed [PROD_BITS-1:0] pix_ext;
      logic signed [PROD_BITS-1:0] coef_ext;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            tap_on = (r != 0 || mask.top) && (r != 2 || mask.bot) &&
                     (c != 0 || mask.left) && (c != 2 || mask.right);
            pix_ext  = PROD_BITS'($signed({1'b0, win[r][c]}));
            coef_ext = PROD_BITS'($signed(kern[r][c]));
            prod_in[r][c] = tap_on ? (pix_ext * coef_ext) : '0;
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sum_in = sum_in + SUM_BITS'(prod_ff[r][c]);
         end
      end
      abs_in = sum_in[SUM_BITS-1] ? ABS_BITS'(-sum_in) : ABS_BITS'(sum_in);
   end

   assign quot_full = QP_BITS'(abs_ff) * QP_BITS'(DIV_MULT[MULT_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         prod_ff <= prod_in;
      end
      if (en.s4) begin
         abs_ff  <= abs_in;
         neg4_ff <= sum_in[SUM_BITS-1];
      end
      if (en.s5) begin
         quot_ff <= quot_full[DIV_SHIFT +: CH_BITS];
         neg5_ff <= neg4_ff;
      end
   end

   assign mag = quot_ff;
   assign neg = neg5_ff;

endmodule

>>> hdl/cvf_merge.sv
// ----------------------------------------------------------------------------
// cvf_merge: result register
// Applies each lane's sign to its quotient, packs the four channels with the
// frame-end flag, and holds the result until the transfer completes.
// ----------------------------------------------------------------------------
module cvf_merge (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic                                      in_fe,
   input  logic [cvf_pkg::LANES-1:0][cvf_pkg::CH_BITS-1:0] lane_mag,
   input  logic [cvf_pkg::LANES-1:0]                 lane_neg,
   output logic                                      ready,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [cvf_pkg::CH_BITS-1:0]               rsp_out_red,
   output logic [cvf_pkg::CH_BITS-1:0]               rsp_out_green,
   output logic [cvf_pkg::CH_BITS-1:0]               rsp_out_blue,
   output logic [cvf_pkg::CH_BITS-1:0]               rsp_out_alpha,
   output logic                                      rsp_frame_end
);
   import cvf_pkg::*;

   logic                             valid_ff;
   logic                             fe_ff;
   logic [LANES-1:0][CH_BITS-1:0]    chan_in, chan_ff;

   always_comb begin
      for (int ch = 0; ch < LANES; ch++) begin
         chan_in[ch] = lane_neg[ch] ? (~lane_mag[ch] + CH_BITS'(1)) : lane_mag[ch];
      end
   end

   assign ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         chan_ff <= chan_in;
         fe_ff   <= in_fe;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_red   = chan_ff[0];
   assign rsp_out_green = chan_ff[1];
   assign rsp_out_blue  = chan_ff[2];
   assign rsp_out_alpha = chan_ff[3];
   assign rsp_frame_end = fe_ff;

endmodule

>>> hdl/conv3x3_rgba_filter_core.sv
// ----------------------------------------------------------------------------
// conv3x3_rgba_filter_core: streaming 3x3 convolution of an RGBA frame
// Two line buffers and a 3x3 window feed four channel lanes; each result is
// the masked weighted sum over nine, truncated toward zero, low byte kept.
//
//   port group   direction   transfer when            carries
//   req_*        in          req_valid && !req_stall  func, pixel channels
//   rsp_*        out         rsp_valid && !rsp_stall  filtered channels, frame end
//   csr_*        in          csr_we                   register index and data
//
// One item per cycle sustained while rsp_stall is low; a result passes stages
// 1 to 5 and the output register. The rate is set by the line buffers, each
// read once per item at the input column and written once per item.
// Reset is synchronous and needs no clearing pass; line buffers hold no reset.
// A stalled result holds in the output register while earlier stages keep
// filling; req_stall rises only when every stage holds an item.
// ----------------------------------------------------------------------------
module conv3x3_rgba_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [cvf_pkg::CH_BITS-1:0]        req_in_red,
   input  logic [cvf_pkg::CH_BITS-1:0]        req_in_green,
   input  logic [cvf_pkg::CH_BITS-1:0]        req_in_blue,
   input  logic [cvf_pkg::CH_BITS-1:0]        req_in_alpha,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cvf_pkg::CH_BITS-1:0]        rsp_out_red,
   output logic [cvf_pkg::CH_BITS-1:0]        rsp_out_green,
   output logic [cvf_pkg::CH_BITS-1:0]        rsp_out_blue,
   output logic [cvf_pkg::CH_BITS-1:0]        rsp_out_alpha,
   output logic                               rsp_frame_end,
   input  logic                               csr_we,
   input  logic [cvf_pkg::CSR_ADDR_BITS-1:0]  csr_index,
   input  logic [cvf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import cvf_pkg::*;

   logic [WREG_BITS-1:0] width_ff;
   logic [HREG_BITS-1:0] height_ff;
   logic [KREG_BITS-1:0] ktop_ff, kmid_ff, kbot_ff;
   logic                 geo_clear;

   logic [WEFF_BITS-1:0] w_eff;
   logic [HREG_BITS-1:0] h_eff;
   kern_type             kern;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5, en6;
   logic fe3_ff, fe4_ff, fe5_ff;

   cvf_cmd_type          cmd;
   cvf_stat_type         stat;
   cvf_lb_req_type       lb_req;
   cvf_lane_en_type      lane_en;
   pix_type              up1, up2;
   win_type              win;
   cvf_mask_type         s2_mask;
   logic                 s2_fe;

   chan_win_type                  lane_win [LANES];
   logic [LANES-1:0][CH_BITS-1:0] lane_mag;
   logic [LANES-1:0]              lane_neg;

   // register file
   assign geo_clear = csr_we &&
                      ((csr_index == REG_IMAGE_WIDTH) || (csr_index == REG_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         ktop_ff   <= KERNEL_RESET;
         kmid_ff   <= KERNEL_RESET;
         kbot_ff   <= KERNEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[WREG_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[HREG_BITS-1:0];
            REG_KERNEL_TOP:   ktop_ff   <= csr_wdata[KREG_BITS-1:0];
            REG_KERNEL_MID:   kmid_ff   <= csr_wdata[KREG_BITS-1:0];
            REG_KERNEL_BOT:   kbot_ff   <= csr_wdata[KREG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [KPACK_BITS-1:0] top_x, mid_x, bot_x;
      if (width_ff == '0) begin
         w_eff = WEFF_BITS'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WEFF_BITS'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_BITS'(width_ff);
      end
      h_eff = (height_ff == '0) ? HREG_BITS'(1) : height_ff;

      top_x = KPACK_BITS'(ktop_ff);
      mid_x = KPACK_BITS'(kmid_ff);
      bot_x = KPACK_BITS'(kbot_ff);
      for (int c = 0; c < 3; c++) begin
         kern[0][c] = top_x[c*COEF_BITS +: COEF_BITS];
         kern[1][c] = mid_x[c*COEF_BITS +: COEF_BITS];
         kern[2][c] = bot_x[c*COEF_BITS +: COEF_BITS];
      end
   end

   // pipeline flow
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall     = !en1;
   assign cmd.accept    = req_valid && en1;
   assign cmd.s1_fire   = v1_ff && en2;
   assign cmd.geo_clear = geo_clear;

   assign lane_en.s3 = en3 && v2_ff;
   assign lane_en.s4 = en4 && v3_ff;
   assign lane_en.s5 = en5 && v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= stat.step;
         if (en2) v2_ff <= v1_ff && stat.s1_emit;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_en.s3) fe3_ff <= s2_fe;
      if (lane_en.s4) fe4_ff <= fe3_ff;
      if (lane_en.s5) fe5_ff <= fe4_ff;
   end

   cvf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_func (req_func),
      .req_pix  ({req_in_alpha, req_in_blue, req_in_green, req_in_red}),
      .w_eff    (w_eff),
      .h_eff    (h_eff),
      .stat     (stat),
      .lb_req   (lb_req),
      .up1      (up1),
      .up2      (up2),
      .win      (win),
      .s2_mask  (s2_mask),
      .s2_fe    (s2_fe)
   );

   cvf_linebuf u_linebuf (
      .clock (clock),
      .req   (lb_req),
      .up1   (up1),
      .up2   (up2)
   );

   always_comb begin
      for (int ch = 0; ch < LANES; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               lane_win[ch][r][c] = win[r][c][ch*CH_BITS +: CH_BITS];
            end
         end
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      cvf_lane u_lane (
         .clock (clock),
         .en    (lane_en),
         .win   (lane_win[g]),
         .kern  (kern),
         .mask  (s2_mask),
         .mag   (lane_mag[g]),
         .neg   (lane_neg[g])
      );
   end

   cvf_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (v5_ff),
      .in_fe         (fe5_ff),
      .lane_mag      (lane_mag),
      .lane_neg      (lane_neg),
      .ready         (en6),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
